FILE: rtl/core/cpls_pkg.sv
// Shared constants, phase codes and types for the program length scanner.
package cpls_pkg;

    localparam int MAX_BYTES = 4096;
    localparam int LEN_W     = 13;
    localparam int SUM_W     = 8;
    localparam int PEND_W    = 5;
    localparam int PHASE_W   = 3;

    localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ALPHA  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LBL2   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LBL3   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd5;
    localparam logic [PHASE_W-1:0] PH_DONE   = 3'd6;

    localparam logic [7:0] DIGIT_LO   = 8'h10;
    localparam logic [7:0] DIGIT_HI   = 8'h1c;
    localparam logic [7:0] ALPHA_MIN  = 8'h1d;
    localparam logic [7:0] LBL_2BYTE  = 8'hce;
    localparam logic [3:0] NIB_F      = 4'hf;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [PEND_W-1:0]  pending;
        logic [LEN_W-1:0]   position;
        logic [SUM_W-1:0]   sum;
    } scan_state_t;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] length;
        logic [SUM_W-1:0] sum;
        logic             end_found;
        logic             truncated;
    } scan_result_t;

    localparam scan_state_t SCAN_RESET = '{
        phase:    PH_START,
        pending:  '0,
        position: '0,
        sum:      '0
    };

endpackage

FILE: rtl/core/cpls_byte_if.sv
// Byte request channel and result channel interfaces for the scanner.
interface cpls_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cpls_result_if;
    logic                            valid;
    logic                            ready;
    logic [cpls_pkg::LEN_W-1:0]      program_length;
    logic [cpls_pkg::SUM_W-1:0]      byte_sum;
    logic                            end_found;
    logic                            truncated;

    modport source (output valid, output program_length, output byte_sum,
                    output end_found, output truncated, input ready);
    modport sink   (input valid, input program_length, input byte_sum,
                    input end_found, input truncated, output ready);
endinterface

FILE: rtl/core/cpls_step.sv
// Next-state and result logic for one image byte.
module cpls_step (
    input  cpls_pkg::scan_state_t  cur,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output cpls_pkg::scan_state_t  nxt,
    output cpls_pkg::scan_result_t res
);

    // returns {phase, pending} for the first byte of an instruction
    function automatic logic [cpls_pkg::PHASE_W+cpls_pkg::PEND_W-1:0] begin_instr(
        input logic [7:0] b
    );
        logic [cpls_pkg::PHASE_W-1:0] ph;
        logic [cpls_pkg::PEND_W-1:0]  pd;
        ph = cpls_pkg::PH_START;
        pd = '0;
        unique case (b[7:4])
            4'h1:
            begin
                ph = (b >= cpls_pkg::ALPHA_MIN) ? cpls_pkg::PH_ALPHA : cpls_pkg::PH_DIGITS;
            end
            4'h9, 4'ha, 4'hb:
            begin
                ph = cpls_pkg::PH_SKIP;
                pd = 5'd1;
            end
            4'hc:
            begin
                if (b >= cpls_pkg::LBL_2BYTE)
                begin
                    ph = cpls_pkg::PH_SKIP;
                    pd = 5'd1;
                end
                else
                begin
                    ph = cpls_pkg::PH_LBL2;
                end
            end
            4'hd, 4'he:
            begin
                ph = cpls_pkg::PH_SKIP;
                pd = 5'd2;
            end
            4'hf:
            begin
                pd = {1'b0, b[3:0]};
                ph = (b[3:0] != 4'h0) ? cpls_pkg::PH_SKIP : cpls_pkg::PH_START;
            end
            default:
            begin
                ph = cpls_pkg::PH_START;
            end
        endcase
        return {ph, pd};
    endfunction

    cpls_pkg::scan_state_t upd;
    logic                  counting;
    logic                  ended;
    logic                  trunc;

    always_comb
    begin
        upd      = cur;
        ended    = 1'b0;
        counting = (cur.phase != cpls_pkg::PH_DONE) &&
                   (cur.position < cpls_pkg::LEN_W'(cpls_pkg::MAX_BYTES));
        if (counting)
        begin
            upd.position = cur.position + 1'b1;
            upd.sum      = cur.sum + data_byte;
            unique case (cur.phase)
                cpls_pkg::PH_DIGITS:
                begin
                    if (data_byte < cpls_pkg::DIGIT_LO || data_byte > cpls_pkg::DIGIT_HI)
                        {upd.phase, upd.pending} = begin_instr(data_byte);
                end
                cpls_pkg::PH_SKIP:
                begin
                    if (cur.pending > 5'd1)
                        upd.pending = cur.pending - 1'b1;
                    else
                    begin
                        upd.pending = '0;
                        upd.phase   = cpls_pkg::PH_START;
                    end
                end
                cpls_pkg::PH_ALPHA:
                begin
                    if (data_byte[7:4] == cpls_pkg::NIB_F && data_byte[3:0] != 4'h0)
                    begin
                        upd.pending = {1'b0, data_byte[3:0]};
                        upd.phase   = cpls_pkg::PH_SKIP;
                    end
                    else
                    begin
                        upd.pending = '0;
                        upd.phase   = cpls_pkg::PH_START;
                    end
                end
                cpls_pkg::PH_LBL2:
                begin
                    upd.phase = cpls_pkg::PH_LBL3;
                end
                cpls_pkg::PH_LBL3:
                begin
                    if (data_byte[7])
                    begin
                        upd.pending = {1'b0, data_byte[3:0]};
                        upd.phase   = (data_byte[3:0] != 4'h0) ? cpls_pkg::PH_SKIP
                                                              : cpls_pkg::PH_START;
                    end
                    else
                    begin
                        upd.phase   = cpls_pkg::PH_DONE;
                        upd.pending = '0;
                        ended       = 1'b1;
                    end
                end
                default:
                begin
                    {upd.phase, upd.pending} = begin_instr(data_byte);
                end
            endcase
        end

        trunc = (upd.phase == cpls_pkg::PH_SKIP) || (upd.phase == cpls_pkg::PH_ALPHA) ||
                (upd.phase == cpls_pkg::PH_LBL2) || (upd.phase == cpls_pkg::PH_LBL3);

        res.length    = upd.position;
        res.sum       = upd.sum;
        res.end_found = ended;
        res.truncated = ended ? 1'b0 : trunc;
        res.valid     = ended || (last_byte && upd.phase != cpls_pkg::PH_DONE);

        nxt = last_byte ? cpls_pkg::SCAN_RESET : upd;
    end

endmodule

FILE: rtl/core/calc_program_length_scanner.sv
// Top level of the calculator program length scanner.
//
//  channel | dir | payload                                          | accepted when
//  image   | in  | data_byte[7:0], last_byte                        | valid && ready
//  result  | out | program_length[12:0], byte_sum[7:0], end_found,  | valid && ready
//          |     | truncated                                        |
//
// One byte per cycle while image ready is high; the scan state updates at the edge that takes the byte.
// A result sits in the output register the cycle after its byte is taken.
// Image ready drops only while a result waits and result.ready is low.
// rst_n clears the scan state and the output valid; no clearing pass.
module calc_program_length_scanner (
    input  logic                  clk,
    input  logic                  rst_n,
    cpls_byte_if.sink             image,
    cpls_result_if.source         result
);

    cpls_pkg::scan_state_t  state_reg;
    cpls_pkg::scan_state_t  state_next;
    cpls_pkg::scan_result_t step_res;

    logic                         res_valid_reg;
    logic [cpls_pkg::LEN_W-1:0]   res_len_reg;
    logic [cpls_pkg::SUM_W-1:0]   res_sum_reg;
    logic                         res_end_reg;
    logic                         res_trunc_reg;
    logic                         take;

    cpls_step u_step (
        .cur       (state_reg),
        .data_byte (image.data_byte),
        .last_byte (image.last_byte),
        .nxt       (state_next),
        .res       (step_res)
    );

    assign image.ready = !res_valid_reg || result.ready;
    assign take        = image.valid && image.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpls_pkg::SCAN_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg     <= state_next;
                res_valid_reg <= step_res.valid;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && step_res.valid)
        begin
            res_len_reg   <= step_res.length;
            res_sum_reg   <= step_res.sum;
            res_end_reg   <= step_res.end_found;
            res_trunc_reg <= step_res.truncated;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.program_length = res_len_reg;
    assign result.byte_sum       = res_sum_reg;
    assign result.end_found      = res_end_reg;
    assign result.truncated      = res_trunc_reg;

endmodule

FILE: sim/calc_program_length_scanner_tb.sv
// Testbench for calc_program_length_scanner: image requests in, length reports checked.
module calc_program_length_scanner_tb;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_BYTES = 400;
    localparam int RANDOM_IMAGES = 40;
    localparam int LONG_IMAGE = cpls_pkg::MAX_BYTES + 5;

    typedef struct {
        logic [7:0] data_byte;
        logic       last_byte;
        int         gap;
        bit         hold;
    } image_byte_t;

    logic clk;
    logic rst_n;

    cpls_byte_if   image_ch ();
    cpls_result_if result_ch ();

    calc_program_length_scanner u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .image  (image_ch),
        .result (result_ch)
    );

    image_byte_t            image_bytes_q[$];
    cpls_pkg::scan_result_t length_reports_q[$];
    logic [7:0]             img[$];

    // scanner state as tracked by the testbench
    logic [cpls_pkg::PHASE_W-1:0] trk_phase;
    logic [cpls_pkg::PEND_W-1:0]  trk_pending;
    logic [cpls_pkg::LEN_W-1:0]   trk_count;
    logic [cpls_pkg::SUM_W-1:0]   trk_sum;

    int fail_cnt = 0;
    int cycle_cnt = 0;
    int tx_max = 19;
    int rx_max = 19;
    int gap_left = 0;
    bit gap_armed = 0;
    int stall_left = 0;
    image_byte_t            next_req;
    cpls_pkg::scan_result_t got_rep;
    cpls_pkg::scan_result_t exp_rep;

    function automatic void clear_scan();
        trk_phase   = cpls_pkg::PH_START;
        trk_pending = '0;
        trk_count   = '0;
        trk_sum     = '0;
    endfunction

    function automatic void arm_skip(input logic [3:0] count);
        trk_pending = cpls_pkg::PEND_W'(count);
        trk_phase   = (count != 0) ? cpls_pkg::PH_SKIP : cpls_pkg::PH_START;
    endfunction

    function automatic void open_instruction(input logic [7:0] b);
        case (b[7:4])
            4'h1:
            begin
                trk_phase   = (b >= cpls_pkg::ALPHA_MIN) ? cpls_pkg::PH_ALPHA
                                                         : cpls_pkg::PH_DIGITS;
                trk_pending = '0;
            end
            4'h9, 4'ha, 4'hb: arm_skip(4'd1);
            4'hc:
            begin
                if (b >= cpls_pkg::LBL_2BYTE)
                begin
                    arm_skip(4'd1);
                end
                else
                begin
                    trk_phase   = cpls_pkg::PH_LBL2;
                    trk_pending = '0;
                end
            end
            4'hd, 4'he: arm_skip(4'd2);
            cpls_pkg::NIB_F: arm_skip(b[3:0]);
            default:
            begin
                trk_phase   = cpls_pkg::PH_START;
                trk_pending = '0;
            end
        endcase
    endfunction

    function automatic void predict_scan_byte(input logic [7:0] b, input logic last);
        cpls_pkg::scan_result_t rep;
        bit ended;
        ended = 0;
        rep = '0;
        if (trk_phase != cpls_pkg::PH_DONE &&
            trk_count < cpls_pkg::LEN_W'(cpls_pkg::MAX_BYTES))
        begin
            trk_count = trk_count + 1'b1;
            trk_sum   = trk_sum + b;
            case (trk_phase)
                cpls_pkg::PH_DIGITS:
                begin
                    if (b < cpls_pkg::DIGIT_LO || b > cpls_pkg::DIGIT_HI)
                        open_instruction(b);
                end
                cpls_pkg::PH_SKIP:
                begin
                    if (trk_pending > 1)
                    begin
                        trk_pending = trk_pending - 1'b1;
                    end
                    else
                    begin
                        trk_pending = '0;
                        trk_phase   = cpls_pkg::PH_START;
                    end
                end
                cpls_pkg::PH_ALPHA: arm_skip((b[7:4] == cpls_pkg::NIB_F) ? b[3:0] : 4'd0);
                cpls_pkg::PH_LBL2: trk_phase = cpls_pkg::PH_LBL3;
                cpls_pkg::PH_LBL3:
                begin
                    if (b[7])
                    begin
                        arm_skip(b[3:0]);
                    end
                    else
                    begin
                        trk_phase   = cpls_pkg::PH_DONE;
                        trk_pending = '0;
                        ended       = 1;
                    end
                end
                default: open_instruction(b);
            endcase
        end
        if (ended)
        begin
            rep.length    = trk_count;
            rep.sum       = trk_sum;
            rep.end_found = 1'b1;
            rep.truncated = 1'b0;
            length_reports_q.push_back(rep);
        end
        if (last)
        begin
            if (!ended && trk_phase != cpls_pkg::PH_DONE)
            begin
                rep.length    = trk_count;
                rep.sum       = trk_sum;
                rep.end_found = 1'b0;
                rep.truncated = (trk_phase == cpls_pkg::PH_SKIP ||
                                 trk_phase == cpls_pkg::PH_ALPHA ||
                                 trk_phase == cpls_pkg::PH_LBL2 ||
                                 trk_phase == cpls_pkg::PH_LBL3);
                length_reports_q.push_back(rep);
            end
            clear_scan();
        end
    endfunction

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
    end

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_ch.valid <= 1'b0;
            image_ch.data_byte <= '0;
            image_ch.last_byte <= 1'b0;
            gap_armed = 0;
            gap_left = 0;
            clear_scan();
        end
        else
        begin
            if (image_ch.valid && image_ch.ready)
                predict_scan_byte(image_ch.data_byte, image_ch.last_byte);
            if (!image_ch.valid || image_ch.ready)
            begin
                if (!gap_armed && image_bytes_q.size() != 0)
                begin
                    gap_left = image_bytes_q[0].gap;
                    gap_armed = 1;
                end
                if (gap_armed && gap_left != 0)
                begin
                    gap_left--;
                    image_ch.valid <= 1'b0;
                end
                else if (gap_armed && image_bytes_q[0].hold && length_reports_q.size() != 0)
                begin
                    image_ch.valid <= 1'b0;
                end
                else if (gap_armed)
                begin
                    next_req = image_bytes_q.pop_front();
                    gap_armed = 0;
                    image_ch.valid <= 1'b1;
                    image_ch.data_byte <= next_req.data_byte;
                    image_ch.last_byte <= next_req.last_byte;
                end
                else
                begin
                    image_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got_rep.length    = result_ch.program_length;
                got_rep.sum       = result_ch.byte_sum;
                got_rep.end_found = result_ch.end_found;
                got_rep.truncated = result_ch.truncated;
                if (length_reports_q.size() == 0)
                begin
                    $error("unexpected result: program_length %0d byte_sum %0d",
                           got_rep.length, got_rep.sum);
                    fail_cnt++;
                end
                else
                begin
                    exp_rep = length_reports_q.pop_front();
                    if (got_rep.length !== exp_rep.length)
                    begin
                        $error("program_length: expected %0d, got %0d",
                               exp_rep.length, got_rep.length);
                        fail_cnt++;
                    end
                    if (got_rep.sum !== exp_rep.sum)
                    begin
                        $error("byte_sum: expected %0d, got %0d", exp_rep.sum, got_rep.sum);
                        fail_cnt++;
                    end
                    if (got_rep.end_found !== exp_rep.end_found)
                    begin
                        $error("end_found: expected %0d, got %0d",
                               exp_rep.end_found, got_rep.end_found);
                        fail_cnt++;
                    end
                    if (got_rep.truncated !== exp_rep.truncated)
                    begin
                        $error("truncated: expected %0d, got %0d",
                               exp_rep.truncated, got_rep.truncated);
                        fail_cnt++;
                    end
                end
                stall_left = (rx_max != 0) ? $urandom_range(0, rx_max) : 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("calc_program_length_scanner_tb: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // appends one well-formed instruction that is never an END
    function automatic void add_instruction();
        int n;
        logic [3:0] hi;
        case ($urandom_range(0, 7))
            0:
            begin
                hi = 4'($urandom_range(0, 7));
                if (hi != 0)
                    hi = hi + 1'b1;
                img.push_back({hi, 4'($urandom_range(0, 15))});
            end
            1:
            begin
                img.push_back({4'($urandom_range(9, 11)), 4'($urandom_range(0, 15))});
                img.push_back(rand_byte());
            end
            2:
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    img.push_back(8'($urandom_range(cpls_pkg::DIGIT_LO, cpls_pkg::DIGIT_HI)));
            end
            3:
            begin
                img.push_back(8'($urandom_range(cpls_pkg::ALPHA_MIN, 8'h1f)));
                if ($urandom_range(0, 1))
                begin
                    n = $urandom_range(0, 15);
                    img.push_back({cpls_pkg::NIB_F, 4'(n)});
                    repeat (n) img.push_back(rand_byte());
                end
                else
                begin
                    img.push_back(8'($urandom_range(0, 8'hef)));
                end
            end
            4:
            begin
                n = $urandom_range(0, 15);
                img.push_back(8'($urandom_range(8'hc0, 8'hcd)));
                img.push_back(rand_byte());
                img.push_back({1'b1, 3'($urandom_range(0, 7)), 4'(n)});
                repeat (n) img.push_back(rand_byte());
            end
            5:
            begin
                img.push_back(8'($urandom_range(cpls_pkg::LBL_2BYTE, 8'hcf)));
                img.push_back(rand_byte());
            end
            6:
            begin
                img.push_back({4'($urandom_range(13, 14)), 4'($urandom_range(0, 15))});
                img.push_back(rand_byte());
                img.push_back(rand_byte());
            end
            default:
            begin
                n = $urandom_range(0, 15);
                img.push_back({cpls_pkg::NIB_F, 4'(n)});
                repeat (n) img.push_back(rand_byte());
            end
        endcase
    endfunction

    function automatic void add_end();
        img.push_back(8'($urandom_range(8'hc0, 8'hcd)));
        img.push_back(rand_byte());
        img.push_back({1'b0, 7'($urandom_range(0, 127))});
    endfunction

    // returns number of bytes up to and including the END, or the whole image
    function automatic int build_image();
        int style;
        int n;
        int cut;
        int counted;
        img.delete();
        style = $urandom_range(0, 9);
        n = $urandom_range(0, 8);
        if (style == 0)
        begin
            repeat ($urandom_range(1, 12)) img.push_back(rand_byte());
            return img.size();
        end
        repeat (n) add_instruction();
        if (style <= 5)
        begin
            add_end();
            counted = img.size();
            if ($urandom_range(0, 1))
                repeat ($urandom_range(1, 3)) img.push_back(rand_byte());
            return counted;
        end
        if (style <= 7)
        begin
            cut = img.size();
            if ($urandom_range(0, 1))
                add_end();
            else
                add_instruction();
            if (img.size() - cut > 1)
            begin
                n = $urandom_range(cut + 1, img.size() - 1);
                while (img.size() > n) void'(img.pop_back());
            end
        end
        if (img.size() == 0)
            add_instruction();
        return img.size();
    endfunction

    function automatic void queue_image(input bit hold);
        image_byte_t req;
        foreach (img[i])
        begin
            req.data_byte = img[i];
            req.last_byte = (i == img.size() - 1);
            req.gap = (tx_max != 0) ? $urandom_range(0, tx_max) : 0;
            req.hold = hold && (i == 0);
            image_bytes_q.push_back(req);
        end
    endfunction

    function automatic void queue_directed(input logic [7:0] bytes[$]);
        img = bytes;
        queue_image(0);
    endfunction

    task automatic drain_reports();
        while (image_bytes_q.size() != 0 || image_ch.valid)
            @(negedge clk);
        while (length_reports_q.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int random_bytes;
        int images;
        int mode;
        random_bytes = 0;
        images = 0;
        wait (rst_n === 1'b1);

        // directed: one-byte image, open text at end, digit run at end,
        // END followed by ignored bytes, END on the last byte, untruncated label tail
        queue_directed('{8'h00});
        queue_directed('{8'hff});
        queue_directed('{8'h10, 8'h1c});
        queue_directed('{8'h1d, 8'hf2, 8'h41, 8'h42, 8'hce, 8'h07, 8'hc0, 8'h00, 8'h0d,
                         8'h55});
        queue_directed('{8'hcd, 8'h00, 8'h7f});
        queue_directed('{8'hc5, 8'h00, 8'hf1, 8'h99, 8'h9a, 8'he0});
        drain_reports();

        // image longer than the byte limit, no idling on either side
        tx_max = 0;
        rx_max = 0;
        img.delete();
        repeat (LONG_IMAGE)
        begin
            mode = $urandom_range(0, 127);
            img.push_back(8'((mode < 16) ? mode : mode + 16));
        end
        queue_image(0);
        drain_reports();

        while (random_bytes < RANDOM_BYTES || images < RANDOM_IMAGES)
        begin
            while (image_bytes_q.size() > 4)
                @(posedge clk);
            mode = $urandom_range(0, 9);
            tx_max = (mode < 3) ? 0 : 19;
            rx_max = (mode == 0 || mode > 6) ? 0 : 19;
            random_bytes += build_image();
            queue_image(images == 0 || $urandom_range(0, 7) == 0);
            images++;
        end
        drain_reports();

        if (fail_cnt == 0 && length_reports_q.size() == 0)
        begin
            $display("calc_program_length_scanner_tb: PASS");
        end
        else
        begin
            $display("calc_program_length_scanner_tb: FAIL");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/cpls_pkg.sv
rtl/core/cpls_byte_if.sv
rtl/core/cpls_step.sv
rtl/core/calc_program_length_scanner.sv
sim/calc_program_length_scanner_tb.sv
